// ----- src/tfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and helpers of the touch frame target classifier.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NUM_TARGETS = 4;
    localparam int TGT_REGS    = 4;
    localparam int N_TGT       = (NUM_TARGETS < TGT_REGS) ? NUM_TARGETS : TGT_REGS;
    localparam int TGT_IDX_W   = $clog2(TGT_REGS);
    localparam int Y_LSB       = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 16;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int DIST_W      = SQ_W + 1;
    localparam int PARM_W      = 16;
    localparam int PSQ_W       = 2 * PARM_W;
    localparam int LIM_W       = ((DIST_W > PSQ_W) ? DIST_W : PSQ_W) + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int Q_DEPTH     = 2;
    localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [BYTE_W-1:0] HDR_MAGIC = 8'hAA;
    localparam logic [POS_W-1:0]  POS_NONE  = 16'hFFFF;

    typedef enum logic [2:0] {
        DRV_STOP     = 3'd0,
        DRV_FORWARD  = 3'd1,
        DRV_BACKWARD = 3'd2,
        DRV_LEFT     = 3'd3,
        DRV_RIGHT    = 3'd4
    } t_drive;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TGT_RT = 3'd0,
        CFG_TGT_RD = 3'd1,
        CFG_TGT_LT = 3'd2,
        CFG_TGT_LD = 3'd3,
        CFG_RADIUS = 3'd4,
        CFG_HYST   = 3'd5
    } t_cfg_idx;

    typedef logic [TGT_REGS-1:0][CFG_DATA_W-1:0] t_tgt_regs;

    localparam t_tgt_regs TGT_RESET = {32'd49153255, 32'd89785670,
                                       32'd55509662, 32'd79954450};
    localparam logic [PARM_W-1:0] RADIUS_RESET = 16'd300;
    localparam logic [PARM_W-1:0] HYST_RESET   = 16'd30;

    // held centre as seen by the front end
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
    } t_held;

    // one classified item between front and back
    typedef struct packed {
        logic                              ok;
        logic [COORD_BITS-1:0]             x;
        logic [COORD_BITS-1:0]             y;
        logic                              near;
        logic [TGT_IDX_W-1:0]              best_i;
        logic [LIM_W-1:0]                  lim;
        logic [N_TGT-1:0][DIST_W-1:0]      tgt_dist;
        logic [DIST_W-1:0]                 d_hc;
    } t_cls;

    function automatic t_drive tgt_mode(input logic [TGT_IDX_W-1:0] idx);
        t_drive m;
        case (idx)
            TGT_IDX_W'(CFG_TGT_RT): m = DRV_RIGHT;
            TGT_IDX_W'(CFG_TGT_RD): m = DRV_BACKWARD;
            TGT_IDX_W'(CFG_TGT_LT): m = DRV_FORWARD;
            TGT_IDX_W'(CFG_TGT_LD): m = DRV_LEFT;
            default:                m = DRV_STOP;
        endcase
        return m;
    endfunction

    function automatic logic [COORD_BITS-1:0] tgt_x(input logic [CFG_DATA_W-1:0] r);
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] tgt_y(input logic [CFG_DATA_W-1:0] r);
        return r[Y_LSB +: COORD_BITS];
    endfunction

endpackage

// ----- src/tfc_front.sv -----
// ----------------------------------------------------------------------------
// tfc_front
// Frame check, decode, squared distances to all targets and the held centre, nearest-target pick, four stages.
// ----------------------------------------------------------------------------
module tfc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_header_byte,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_x_low,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_x_high,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_y_low,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_y_high,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_check_byte,
    input  tfc_pkg::t_tgt_regs                i_targets,
    input  logic [tfc_pkg::PARM_W-1:0]        i_radius,
    input  logic [tfc_pkg::PARM_W-1:0]        i_hyst,
    input  tfc_pkg::t_held                    i_held,
    input  logic                              i_full,
    output logic                              o_push,
    output tfc_pkg::t_cls                     o_cls
);
    import tfc_pkg::*;

    localparam int LANES = N_TGT + 1;
    localparam int HL    = N_TGT;   // lane of the held centre

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic                  rdy1, rdy2, rdy3, rdy4, accept;
    logic [BYTE_W-1:0]     sum5;
    logic [2*BYTE_W-1:0]   raw_x, raw_y;

    logic                  r_v1, r_ok1;
    logic [COORD_BITS-1:0] r_x1, r_y1;
    logic                  r_v2, r_ok2;
    logic [COORD_BITS-1:0] r_x2, r_y2;
    logic [COORD_BITS-1:0] r_dx2 [LANES];
    logic [COORD_BITS-1:0] r_dy2 [LANES];
    logic                  r_v3, r_ok3;
    logic [COORD_BITS-1:0] r_x3, r_y3;
    logic [SQ_W-1:0]       r_sx3 [LANES];
    logic [SQ_W-1:0]       r_sy3 [LANES];
    logic                  r_v4, r_ok4;
    logic [COORD_BITS-1:0] r_x4, r_y4;
    logic [DIST_W-1:0]     r_d4 [LANES];
    logic [PSQ_W-1:0]      r_rsq4, r_hsq4;

    logic [COORD_BITS-1:0] n_dx [LANES];
    logic [COORD_BITS-1:0] n_dy [LANES];
    logic [DIST_W-1:0]     best;
    logic [TGT_IDX_W-1:0]  best_i;

    assign rdy4    = !r_v4 || !i_full;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign accept  = i_valid && rdy1;
    assign o_push  = r_v4 && !i_full;

    assign sum5  = i_header_byte + i_x_low + i_x_high + i_y_low + i_y_high;
    assign raw_x = {i_x_high, i_x_low};
    assign raw_y = {i_y_high, i_y_low};

    always_comb begin
        for (int i = 0; i < N_TGT; i++) begin
            n_dx[i] = abs_diff(r_x1, tgt_x(i_targets[i]));
            n_dy[i] = abs_diff(r_y1, tgt_y(i_targets[i]));
        end
        n_dx[HL] = abs_diff(r_x1, i_held.cx);
        n_dy[HL] = abs_diff(r_y1, i_held.cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok1 <= (i_header_byte == HDR_MAGIC) && (sum5 == i_check_byte);
            r_x1  <= raw_x[COORD_BITS-1:0];
            r_y1  <= raw_y[COORD_BITS-1:0];
        end
        if (rdy2 && r_v1) begin
            r_ok2 <= r_ok1;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            for (int i = 0; i < LANES; i++) begin
                r_dx2[i] <= n_dx[i];
                r_dy2[i] <= n_dy[i];
            end
        end
        if (rdy3 && r_v2) begin
            r_ok3 <= r_ok2;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            for (int i = 0; i < LANES; i++) begin
                r_sx3[i] <= SQ_W'(r_dx2[i]) * SQ_W'(r_dx2[i]);
                r_sy3[i] <= SQ_W'(r_dy2[i]) * SQ_W'(r_dy2[i]);
            end
        end
        if (rdy4 && r_v3) begin
            r_ok4  <= r_ok3;
            r_x4   <= r_x3;
            r_y4   <= r_y3;
            r_rsq4 <= PSQ_W'(i_radius) * PSQ_W'(i_radius);
            r_hsq4 <= PSQ_W'(i_hyst) * PSQ_W'(i_hyst);
            for (int i = 0; i < LANES; i++) begin
                r_d4[i] <= DIST_W'(r_sx3[i]) + DIST_W'(r_sy3[i]);
            end
        end
    end

    // nearest target, strict less so the first one wins a tie
    always_comb begin
        best   = r_d4[0];
        best_i = '0;
        for (int i = 1; i < N_TGT; i++) begin
            if (r_d4[i] < best) begin
                best   = r_d4[i];
                best_i = TGT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_cls.ok     = r_ok4;
        o_cls.x      = r_x4;
        o_cls.y      = r_y4;
        o_cls.near   = LIM_W'(best) <= LIM_W'(r_rsq4);
        o_cls.best_i = best_i;
        o_cls.lim    = LIM_W'(best) + LIM_W'(r_hsq4);
        for (int i = 0; i < N_TGT; i++) begin
            o_cls.tgt_dist[i] = r_d4[i];
        end
        o_cls.d_hc   = r_d4[HL];
    end

endmodule

// ----- src/tfc_queue.sv -----
// ----------------------------------------------------------------------------
// tfc_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module tfc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfc_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tfc_pkg::t_cls o_data
);
    import tfc_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wp, r_rp;
    logic [QP_W:0]   r_cnt;

    function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
        return (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = r_cnt == (QP_W + 1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- src/tfc_back.sv -----
// ----------------------------------------------------------------------------
// tfc_back
// Hysteresis decision on the held target and the registered result item.
// ----------------------------------------------------------------------------
module tfc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  tfc_pkg::t_tgt_regs            i_targets,
    input  logic                          i_q_valid,
    input  tfc_pkg::t_cls                 i_cls,
    output logic                          o_pop,
    output tfc_pkg::t_held                o_held,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_frame_ok,
    output logic                          o_touching,
    output logic [tfc_pkg::POS_W-1:0]     o_pos_x,
    output logic [tfc_pkg::POS_W-1:0]     o_pos_y,
    output tfc_pkg::t_drive               o_drive
);
    import tfc_pkg::*;

    t_drive                r_mode, n_mode;
    logic [COORD_BITS-1:0] r_cx, r_cy, n_cx, n_cy;
    // r_hv: held centre equals target r_hidx as configured now
    logic                  r_hv, n_hv;
    logic [TGT_IDX_W-1:0]  r_hidx, n_hidx;

    logic                  r_out_v;
    logic                  r_ok, r_touch;
    logic [POS_W-1:0]      r_px, r_py;
    t_drive                r_drv;

    logic [DIST_W-1:0]     d_held;
    t_drive                n_drv;
    logic [POS_W-1:0]      n_px, n_py;

    assign o_pop  = i_q_valid && (!r_out_v || !i_stall);
    assign d_held = r_hv ? i_cls.tgt_dist[r_hidx] : i_cls.d_hc;
    assign n_px   = i_cls.ok ? POS_W'(i_cls.x) : POS_NONE;
    assign n_py   = i_cls.ok ? POS_W'(i_cls.y) : POS_NONE;

    always_comb begin
        n_mode = r_mode;
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_hv   = r_hv;
        n_hidx = r_hidx;
        n_drv  = DRV_STOP;
        if (i_cls.ok) begin
            if (!i_cls.near) begin
                n_mode = DRV_STOP;
            end else if (r_mode != DRV_STOP && LIM_W'(d_held) <= i_cls.lim) begin
                n_drv = r_mode;
            end else begin
                n_mode = tgt_mode(i_cls.best_i);
                n_cx   = tgt_x(i_targets[i_cls.best_i]);
                n_cy   = tgt_y(i_targets[i_cls.best_i]);
                n_hv   = 1'b1;
                n_hidx = i_cls.best_i;
                n_drv  = n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= DRV_STOP;
            r_cx    <= '0;
            r_cy    <= '0;
            r_hv    <= 1'b0;
            r_hidx  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hv <= 1'b0;
            end else if (o_pop) begin
                r_mode <= n_mode;
                r_cx   <= n_cx;
                r_cy   <= n_cy;
                r_hv   <= n_hv;
                r_hidx <= n_hidx;
            end
            if (o_pop)          r_out_v <= 1'b1;
            else if (!i_stall)  r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok    <= i_cls.ok;
            r_touch <= i_cls.ok && !(n_px == POS_NONE && n_py == POS_NONE);
            r_px    <= n_px;
            r_py    <= n_py;
            r_drv   <= n_drv;
        end
    end

    assign o_held.cx  = r_cx;
    assign o_held.cy  = r_cy;
    assign o_valid    = r_out_v;
    assign o_frame_ok = r_ok;
    assign o_touching = r_touch;
    assign o_pos_x    = r_px;
    assign o_pos_y    = r_py;
    assign o_drive    = r_drv;

endmodule

// ----- src/touch_frame_target_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// touch_frame_target_classifier_unit
// Touch frame checker and nearest-target drive classifier with hysteresis.
// ----------------------------------------------------------------------------
// Takes one six-byte touch frame per cycle while not stalled and gives one
// result item per frame, in order. A frame passes four front stages (decode,
// differences, squares, sums), the two-entry queue and the output register
// of the decision stage, the first stage being loaded at the accepting edge.
// The decision on the held target closes its loop within the decision stage,
// so the sustained rate is one item per cycle when the output is not stalled.
// Configuration writes are always ready and take effect at once; they are
// meant for idle periods.
// ----------------------------------------------------------------------------
module touch_frame_target_classifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_header_byte,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_x_low,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_x_high,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_y_low,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_y_high,
    input  logic [tfc_pkg::BYTE_W-1:0]        i_check_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_frame_ok,
    output logic                              o_touching,
    output logic [tfc_pkg::POS_W-1:0]         o_pos_x,
    output logic [tfc_pkg::POS_W-1:0]         o_pos_y,
    output tfc_pkg::t_drive                   o_drive,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tfc_pkg::*;

    t_tgt_regs         r_tgt;
    logic [PARM_W-1:0] r_radius, r_hyst;
    logic              cfg_we;

    logic              push, full, pop, q_valid;
    t_cls              cls_in, cls_out;
    t_held             held;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt    <= TGT_RESET;
            r_radius <= RADIUS_RESET;
            r_hyst   <= HYST_RESET;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TGT_RT: r_tgt[CFG_TGT_RT] <= i_cfg_data;
                CFG_TGT_RD: r_tgt[CFG_TGT_RD] <= i_cfg_data;
                CFG_TGT_LT: r_tgt[CFG_TGT_LT] <= i_cfg_data;
                CFG_TGT_LD: r_tgt[CFG_TGT_LD] <= i_cfg_data;
                CFG_RADIUS: r_radius <= i_cfg_data[PARM_W-1:0];
                CFG_HYST:   r_hyst   <= i_cfg_data[PARM_W-1:0];
                default: ;
            endcase
        end
    end

    tfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_header_byte (i_header_byte),
        .i_x_low       (i_x_low),
        .i_x_high      (i_x_high),
        .i_y_low       (i_y_low),
        .i_y_high      (i_y_high),
        .i_check_byte  (i_check_byte),
        .i_targets     (r_tgt),
        .i_radius      (r_radius),
        .i_hyst        (r_hyst),
        .i_held        (held),
        .i_full        (full),
        .o_push        (push),
        .o_cls         (cls_in)
    );

    tfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (cls_out)
    );

    tfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_targets  (r_tgt),
        .i_q_valid  (q_valid),
        .i_cls      (cls_out),
        .o_pop      (pop),
        .o_held     (held),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_frame_ok (o_frame_ok),
        .o_touching (o_touching),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_drive    (o_drive)
    );

endmodule

// ----- src/tfc_checker.sv -----
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks of the classifier result stream.
// ----------------------------------------------------------------------------
module tfc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_frame_ok,
    input  logic                          o_touching,
    input  logic [tfc_pkg::POS_W-1:0]     o_pos_x,
    input  logic [tfc_pkg::POS_W-1:0]     o_pos_y,
    input  tfc_pkg::t_drive               o_drive
);
    import tfc_pkg::*;

    // a stalled item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
                               && $stable(o_drive) && $stable(o_frame_ok))
        else $error("stalled item changed");

    // a bad frame stops the car and reports no position
    a_bad_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_ok |-> o_drive == DRV_STOP && !o_touching
                                   && o_pos_x == POS_NONE && o_pos_y == POS_NONE)
        else $error("bad frame item not neutral");

    a_touch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_touching |-> o_frame_ok
                                  && !(o_pos_x == POS_NONE && o_pos_y == POS_NONE))
        else $error("touching flag inconsistent");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind touch_frame_target_classifier_unit tfc_checker u_tfc_checker (.*);
